>>> rtl/rcdm_pkg.sv
// Package for the RC differential drive mixer: field widths, configuration
// register indexes and reset values, the divisor codes of the shared scale unit,
// and the structs that pass between the modules. It depends on nothing else.
package rcdm_pkg;

    localparam int CHAN_W      = 11;
    localparam int DB_W        = 8;
    localparam int PCT_W       = 7;
    localparam int DUTY_W      = 8;
    localparam int OPA_W       = 12;
    localparam int FACT_W      = 8;
    localparam int PROD_W      = 20;
    localparam int RECIP_W     = 17;
    localparam int QUO_W       = 12;
    localparam int RECIP_SHIFT = 20;
    localparam int DIVISOR_W   = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CENTER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MOVE_DB   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TURN_DB   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FULL_PCT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LOW_PCT   = 3'd4;

    // Mixing factors as integer numerators.
    localparam logic [FACT_W-1:0] FAST_NUM        = 8'd125;
    localparam logic [FACT_W-1:0] SLOW_NUM        = 8'd85;
    localparam logic [FACT_W-1:0] PIVOT_BIG_NUM   = 8'd11;
    localparam logic [FACT_W-1:0] PIVOT_SMALL_NUM = 8'd9;
    localparam logic [FACT_W-1:0] DUTY_NUM        = 8'd255;

    typedef struct packed {
        logic [CHAN_W-1:0] center;
        logic [DB_W-1:0]   move_db;
        logic [DB_W-1:0]   turn_db;
        logic [PCT_W-1:0]  full_pct;
        logic [PCT_W-1:0]  low_pct;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        center:   11'd1500,
        move_db:  8'd25,
        turn_db:  8'd15,
        full_pct: 7'd75,
        low_pct:  7'd60
    };

    // Constant divisors the scale unit supports.
    typedef enum logic [1:0] {
        DIV_100 = 2'd0,
        DIV_10  = 2'd1,
        DIV_500 = 2'd2
    } t_div;

    typedef struct packed {
        logic             start;
        logic [OPA_W-1:0] a;
        logic [FACT_W-1:0] m;
        t_div             div;
    } t_scale_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] q;
    } t_scale_rsp;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_right;
        logic [DUTY_W-1:0] duty_left;
        logic              reverse_right;
        logic              reverse_left;
        logic              brake_active;
    } t_result;

    function automatic logic [DIVISOR_W-1:0] divisor_of(input t_div d);
        logic [DIVISOR_W-1:0] v;
        case (d)
            DIV_100: v = 9'd100;
            DIV_10:  v = 9'd10;
            DIV_500: v = 9'd500;
            default: v = 9'd100;
        endcase
        return v;
    endfunction

    // floor(2^20 / d); the quotient estimate is then low by at most one.
    function automatic logic [RECIP_W-1:0] recip_of(input t_div d);
        logic [RECIP_W-1:0] v;
        case (d)
            DIV_100: v = 17'd10485;
            DIV_10:  v = 17'd104857;
            DIV_500: v = 17'd2097;
            default: v = 17'd10485;
        endcase
        return v;
    endfunction

    function automatic logic [DUTY_W-1:0] sat_duty(input logic [QUO_W-1:0] q);
        return (|q[QUO_W-1:DUTY_W]) ? {DUTY_W{1'b1}} : q[DUTY_W-1:0];
    endfunction

endpackage

>>> rtl/rc_differential_drive_mixer.sv
// RC differential drive mixer, top level. Holds the configuration bank, the
// sequencer, the shared scale unit and the output register; uses rcdm_pkg.
//
// Each input transaction is one decoded RC frame: the link flag in tuser and
// five 11-bit channels in tdata. Each accepted frame produces exactly one output
// transaction with the right and left motor duties and the reverse and brake
// lines. With the link lost both duties are zero and the speed mode, reverse
// and brake state are kept. A frame that needs mixing is classified, then makes
// five passes through the shared multiply-and-divide unit (the speed percent,
// the two turn factors and the two duty conversions), and its result is handed
// to the output register before the next frame can be accepted. Frames with
// lost link, brake, or a centered stick skip the passes. A result that cannot
// enter a full output register holds the sequencer until that register is free.
// A finished result waits in the output register, so the next frame is taken
// while the previous result has not yet been accepted downstream. Configuration
// registers (index 0 center value, 1 throttle deadband, 2 steering deadband, 3
// full speed percent, 4 low speed percent) are written through their own
// channel, which is always ready, and should be written only while idle.
module rc_differential_drive_mixer
    import rcdm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input frame channel.
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata, lowest bit up: throttle[10:0], steering[21:11],
    // brake_channel[32:22], turn_mode_channel[43:33], speed_channel[54:44],
    // zero padding[55].
    input  logic [55:0]           i_s_axis_tdata,
    // tuser: link_valid[0].
    input  logic [0:0]            i_s_axis_tuser,
    // Result channel.
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata, lowest bit up: duty_right[7:0], duty_left[15:8],
    // reverse_right[16], reverse_left[17], brake_active[18], zero padding[23:19].
    output logic [23:0]           o_m_axis_tdata,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg       cfg;
    t_scale_req scale_req;
    t_scale_rsp scale_rsp;
    t_result    seq_res;
    logic       seq_push;
    logic       slot_free;

    logic    r_out_valid;
    t_result r_out;

    rcdm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rcdm_scale_unit u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (scale_req),
        .o_rsp   (scale_rsp)
    );

    rcdm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_link      (i_s_axis_tuser[0]),
        .i_move      (i_s_axis_tdata[10:0]),
        .i_turn      (i_s_axis_tdata[21:11]),
        .i_brake     (i_s_axis_tdata[32:22]),
        .i_turn_mode (i_s_axis_tdata[43:33]),
        .i_speed     (i_s_axis_tdata[54:44]),
        .o_req       (scale_req),
        .i_rsp       (scale_rsp),
        .i_slot_free (slot_free),
        .o_push      (seq_push),
        .o_res       (seq_res)
    );

    // The output register is free when empty or when its result leaves now.
    assign slot_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_push) begin
            r_out <= seq_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out.brake_active, r_out.reverse_left,
                              r_out.reverse_right, r_out.duty_left, r_out.duty_right};

endmodule

>>> rtl/rcdm_cfg_regs.sv
// Configuration register bank of the RC differential drive mixer.
// Depends on rcdm_pkg for the register indexes, reset values and t_cfg.
module rcdm_cfg_regs
    import rcdm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Writes to indexes beyond the list are accepted and dropped.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IDX_CENTER:   n_cfg.center   = i_cfg_data;
                CFG_IDX_MOVE_DB:  n_cfg.move_db  = i_cfg_data[DB_W-1:0];
                CFG_IDX_TURN_DB:  n_cfg.turn_db  = i_cfg_data[DB_W-1:0];
                CFG_IDX_FULL_PCT: n_cfg.full_pct = i_cfg_data[PCT_W-1:0];
                CFG_IDX_LOW_PCT:  n_cfg.low_pct  = i_cfg_data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> rtl/rcdm_scale_unit.sv
// Shared scale unit: computes floor(a * m / d) for d of 100, 10 or 500 with one
// multiplier used three times (product, reciprocal estimate, remainder check).
// Depends on rcdm_pkg for the request and response structs and the constants.
module rcdm_scale_unit
    import rcdm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_scale_req i_req,
    output t_scale_rsp o_rsp
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_RCP  = 3'b010,
        PH_FIX  = 3'b100
    } t_phase;

    t_phase r_phase;
    t_phase n_phase;
    logic   r_done;

    logic [PROD_W-1:0] r_p;
    logic [QUO_W-1:0]  r_q0;
    logic [QUO_W-1:0]  r_q;
    t_div              r_div;

    logic [PROD_W-1:0]         mul_x;
    logic [RECIP_W-1:0]        mul_y;
    logic [PROD_W+RECIP_W-1:0] mul_prod;
    logic [PROD_W-1:0]         rem;
    logic [QUO_W-1:0]          q_fix;

    // One multiplier; its operands follow the phase.
    always_comb begin
        case (r_phase)
            PH_RCP: begin
                mul_x = r_p;
                mul_y = recip_of(r_div);
            end
            PH_FIX: begin
                mul_x = {{(PROD_W-QUO_W){1'b0}}, r_q0};
                mul_y = {{(RECIP_W-DIVISOR_W){1'b0}}, divisor_of(r_div)};
            end
            default: begin
                mul_x = {{(PROD_W-OPA_W){1'b0}}, i_req.a};
                mul_y = {{(RECIP_W-FACT_W){1'b0}}, i_req.m};
            end
        endcase
    end

    assign mul_prod = mul_x * mul_y;

    // The estimate is the true quotient or one less; the remainder decides.
    assign rem   = r_p - mul_prod[PROD_W-1:0];
    assign q_fix = (rem >= {{(PROD_W-DIVISOR_W){1'b0}}, divisor_of(r_div)}) ?
                   r_q0 + QUO_W'(1) : r_q0;

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE: if (i_req.start) n_phase = PH_RCP;
            PH_RCP:  n_phase = PH_FIX;
            PH_FIX:  n_phase = PH_IDLE;
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == PH_FIX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == PH_IDLE && i_req.start) begin
            r_p   <= mul_prod[PROD_W-1:0];
            r_div <= i_req.div;
        end
        if (r_phase == PH_RCP) begin
            r_q0 <= mul_prod[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
        end
        if (r_phase == PH_FIX) begin
            r_q <= q_fix;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;

endmodule

>>> rtl/rcdm_seq.sv
// Sequencer of the RC differential drive mixer: classifies a frame, keeps the
// speed mode, reverse and brake state, and drives the shared scale unit.
// Depends on rcdm_pkg and pairs with rcdm_scale_unit.
module rcdm_seq
    import rcdm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_link,
    input  logic [CHAN_W-1:0] i_move,
    input  logic [CHAN_W-1:0] i_turn,
    input  logic [CHAN_W-1:0] i_brake,
    input  logic [CHAN_W-1:0] i_turn_mode,
    input  logic [CHAN_W-1:0] i_speed,
    output t_scale_req        o_req,
    input  t_scale_rsp        i_rsp,
    input  logic              i_slot_free,
    output logic              o_push,
    output t_result           o_res
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_CLASSIFY = 9'b000000010,
        ST_LAUNCH   = 9'b000000100,
        ST_OP_A     = 9'b000001000,
        ST_OP_B     = 9'b000010000,
        ST_OP_C     = 9'b000100000,
        ST_OP_D     = 9'b001000000,
        ST_OP_E     = 9'b010000000,
        ST_HOLD     = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // Persistent state.
    logic r_low, n_low;
    logic r_rev_r, n_rev_r;
    logic r_rev_l, n_rev_l;
    logic r_brake, n_brake;

    // Captured frame.
    logic              r_link;
    logic [CHAN_W-1:0] r_mv, r_tn, r_br, r_tm, r_sp;

    // Per-frame working registers.
    logic              r_move, n_move;
    logic              r_back, n_back;
    logic              r_turn_r, n_turn_r;
    logic              r_turn_l_q, n_turn_l;
    logic              r_one_wheel, n_one_wheel;
    logic [CHAN_W-1:0] r_mag, n_mag;
    logic [PCT_W-1:0]  r_pct, n_pct;
    logic [QUO_W-1:0]  r_v, n_v;
    logic [QUO_W-1:0]  r_qb, n_qb;
    logic [QUO_W-1:0]  r_speed_l, n_speed_l;
    logic [DUTY_W-1:0] r_duty_r, n_duty_r;
    logic [DUTY_W-1:0] r_duty_l, n_duty_l;

    logic signed [CHAN_W:0] thr, str, mdb, tdb;
    logic                   fwd, back, turn_r, turn_l, low_cls;
    logic [CHAN_W-1:0]      mag_thr, mag_str;
    logic [QUO_W-1:0]       fast, slow, sel_r, sel_l;
    logic                   left_fast;

    assign thr = $signed({1'b0, r_mv}) - $signed({1'b0, i_cfg.center});
    assign str = $signed({1'b0, r_tn}) - $signed({1'b0, i_cfg.center});
    assign mdb = $signed({{(CHAN_W+1-DB_W){1'b0}}, i_cfg.move_db});
    assign tdb = $signed({{(CHAN_W+1-DB_W){1'b0}}, i_cfg.turn_db});

    assign fwd     = thr > mdb;
    assign back    = thr < -mdb;
    assign turn_r  = str > tdb;
    assign turn_l  = str < -tdb;
    assign mag_thr = thr[CHAN_W] ? CHAN_W'(-thr) : thr[CHAN_W-1:0];
    assign mag_str = str[CHAN_W] ? CHAN_W'(-str) : str[CHAN_W-1:0];
    assign low_cls = (r_sp > i_cfg.center) ? 1'b1 :
                     (r_sp < i_cfg.center) ? 1'b0 : r_low;

    // Wheel speeds once both mixed values are known; i_rsp.q is the third.
    always_comb begin
        fast      = r_one_wheel ? r_v : r_qb;
        slow      = r_one_wheel ? '0  : i_rsp.q;
        left_fast = r_turn_r != r_back;
        if (r_move) begin
            if (r_turn_r || r_turn_l_q) begin
                sel_l = left_fast ? fast : slow;
                sel_r = left_fast ? slow : fast;
            end else begin
                sel_l = r_v;
                sel_r = r_v;
            end
        end else if (r_turn_r) begin
            sel_r = r_qb;
            sel_l = i_rsp.q;
        end else begin
            sel_r = i_rsp.q;
            sel_l = r_qb;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_low       = r_low;
        n_rev_r     = r_rev_r;
        n_rev_l     = r_rev_l;
        n_brake     = r_brake;
        n_move      = r_move;
        n_back      = r_back;
        n_turn_r    = r_turn_r;
        n_turn_l    = r_turn_l_q;
        n_one_wheel = r_one_wheel;
        n_mag       = r_mag;
        n_pct       = r_pct;
        n_v         = r_v;
        n_qb        = r_qb;
        n_speed_l   = r_speed_l;
        n_duty_r    = r_duty_r;
        n_duty_l    = r_duty_l;
        o_req       = '{start: 1'b0, a: '0, m: '0, div: DIV_100};
        o_push      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_CLASSIFY;
            end
            ST_CLASSIFY: begin
                n_duty_r = '0;
                n_duty_l = '0;
                n_state  = ST_HOLD;
                if (r_link) begin
                    n_low       = low_cls;
                    n_pct       = low_cls ? i_cfg.low_pct : i_cfg.full_pct;
                    n_brake     = r_br < i_cfg.center;
                    n_move      = fwd || back;
                    n_back      = back;
                    n_turn_r    = turn_r;
                    n_turn_l    = turn_l;
                    n_one_wheel = r_tm < i_cfg.center;
                    if (r_br < i_cfg.center) begin
                        n_state = ST_HOLD;
                    end else if (fwd || back) begin
                        n_rev_r = back;
                        n_rev_l = back;
                        n_mag   = mag_thr;
                        n_state = ST_LAUNCH;
                    end else begin
                        n_rev_r = turn_r;
                        n_rev_l = turn_l;
                        n_mag   = mag_str;
                        if (turn_r || turn_l) n_state = ST_LAUNCH;
                    end
                end
            end
            ST_LAUNCH: begin
                o_req   = '{start: 1'b1, a: {1'b0, r_mag},
                            m: {1'b0, r_pct}, div: DIV_100};
                n_state = ST_OP_A;
            end
            ST_OP_A: begin
                if (i_rsp.done) begin
                    n_v     = i_rsp.q;
                    o_req   = '{start: 1'b1, a: i_rsp.q,
                                m: r_move ? FAST_NUM : PIVOT_BIG_NUM,
                                div: r_move ? DIV_100 : DIV_10};
                    n_state = ST_OP_B;
                end
            end
            ST_OP_B: begin
                if (i_rsp.done) begin
                    n_qb    = i_rsp.q;
                    o_req   = '{start: 1'b1, a: r_v,
                                m: r_move ? SLOW_NUM : PIVOT_SMALL_NUM,
                                div: r_move ? DIV_100 : DIV_10};
                    n_state = ST_OP_C;
                end
            end
            ST_OP_C: begin
                if (i_rsp.done) begin
                    n_speed_l = sel_l;
                    o_req     = '{start: 1'b1, a: sel_r, m: DUTY_NUM, div: DIV_500};
                    n_state   = ST_OP_D;
                end
            end
            ST_OP_D: begin
                if (i_rsp.done) begin
                    n_duty_r = sat_duty(i_rsp.q);
                    o_req    = '{start: 1'b1, a: r_speed_l, m: DUTY_NUM, div: DIV_500};
                    n_state  = ST_OP_E;
                end
            end
            ST_OP_E: begin
                if (i_rsp.done) begin
                    n_duty_l = sat_duty(i_rsp.q);
                    n_state  = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (i_slot_free) begin
                    o_push  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

    assign o_res.duty_right    = r_duty_r;
    assign o_res.duty_left     = r_duty_l;
    assign o_res.reverse_right = r_rev_r;
    assign o_res.reverse_left  = r_rev_l;
    assign o_res.brake_active  = r_brake;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_low   <= 1'b1;
            r_rev_r <= 1'b0;
            r_rev_l <= 1'b0;
            r_brake <= 1'b0;
        end else begin
            r_state <= n_state;
            r_low   <= n_low;
            r_rev_r <= n_rev_r;
            r_rev_l <= n_rev_l;
            r_brake <= n_brake;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_link <= i_link;
            r_mv   <= i_move;
            r_tn   <= i_turn;
            r_br   <= i_brake;
            r_tm   <= i_turn_mode;
            r_sp   <= i_speed;
        end
        r_move      <= n_move;
        r_back      <= n_back;
        r_turn_r    <= n_turn_r;
        r_turn_l_q  <= n_turn_l;
        r_one_wheel <= n_one_wheel;
        r_mag       <= n_mag;
        r_pct       <= n_pct;
        r_v         <= n_v;
        r_qb        <= n_qb;
        r_speed_l   <= n_speed_l;
        r_duty_r    <= n_duty_r;
        r_duty_l    <= n_duty_l;
    end

endmodule

>>> rtl/rcdm_checker.sv
// Port-level checker for the RC differential drive mixer, attached to the top
// level by the bind statement at the end of this file. No package needed.
module rcdm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata
);

    // A frame is worked on after it is accepted, so ready drops after a transaction.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("ready stayed high after an input transaction");

    // A result showing the brake line always carries zero duties.
    a_brake_zero_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[18]) |-> (o_m_axis_tdata[15:0] == 16'd0))
        else $error("brake active with nonzero duty");

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("output result changed or dropped while stalled");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind rc_differential_drive_mixer rcdm_checker u_rcdm_checker (.*);
